// ===== rtl/framed_command_receiver_top_macros.svh =====
// -----------------------------------------------------------------------------
// Framed command receiver assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define FCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FCR_ASSERT_IMP(label, ante, cons, msg)
`define FCR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/fcr_pkg.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver package
// Types, command codes and field widths shared by the receiver modules.
// -----------------------------------------------------------------------------
package fcr_pkg;

    localparam int BYTE_W   = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int TDATA_W  = 24;
    localparam int TUSER_W  = 2;

    localparam logic [BYTE_W-1:0] CHECK_MASK  = 8'h0F;
    localparam logic [BYTE_W-1:0] SCORE_MAX   = 8'd99;
    localparam logic [BYTE_W-1:0] SCORE_100   = 8'd100;
    localparam logic [BYTE_W-1:0] SCORE_200   = 8'd200;
    localparam logic [BYTE_W-1:0] PERIOD_MAX  = 8'd4;
    localparam logic [BYTE_W-1:0] PERIOD_CLIP = 8'd10;
    localparam logic [BYTE_W-1:0] STOP_ON     = 8'd1;

    // Command codes.
    localparam logic [BYTE_W-1:0] CMD_SCORE_HOME   = 8'd200;
    localparam logic [BYTE_W-1:0] CMD_STORE_H1     = 8'd201;
    localparam logic [BYTE_W-1:0] CMD_STORE_H2     = 8'd202;
    localparam logic [BYTE_W-1:0] CMD_SCORE_GUEST  = 8'd210;
    localparam logic [BYTE_W-1:0] CMD_STORE_G1     = 8'd211;
    localparam logic [BYTE_W-1:0] CMD_STORE_G2     = 8'd212;
    localparam logic [BYTE_W-1:0] CMD_PERIOD       = 8'd220;
    localparam logic [BYTE_W-1:0] CMD_STORE_P1     = 8'd221;
    localparam logic [BYTE_W-1:0] CMD_CLOCK_STOP   = 8'd222;
    localparam logic [BYTE_W-1:0] CMD_CLOCK_ADJUST = 8'd223;
    localparam logic [BYTE_W-1:0] CMD_BUZZER       = 8'd80;

    // Register addresses.
    localparam logic [APB_AW-1:0] ADDR_START_MARKER = 3'd0;

    typedef enum logic [1:0] {
        POS_START,
        POS_COMMAND,
        POS_DATA,
        POS_CHECK
    } fcr_pos_t;

    typedef enum logic [1:0] {
        ACT_LOCAL   = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_BUZZER  = 2'd2
    } fcr_action_t;

    // A framed packet whose checksum matched.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] data;
    } fcr_pkt_t;

    typedef struct packed {
        fcr_action_t       action;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] value;
        logic              hundreds;
        logic              clock_stopped;
        logic              clock_set_by_host;
    } fcr_result_t;

endpackage

// ===== rtl/fcr_framer.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver packet framer
// Tracks the byte slot, holds command and data, and checks the checksum.
// -----------------------------------------------------------------------------
module fcr_framer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [fcr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [fcr_pkg::BYTE_W-1:0]    start_marker,
    output fcr_pkg::fcr_pkt_t             pkt,
    output fcr_pkg::fcr_pos_t             pos
);
    import fcr_pkg::*;

    fcr_pos_t          pos_reg, pos_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_START;
            check_reg <= '0;
            cmd_reg   <= '0;
            data_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            check_reg <= check_next;
            cmd_reg   <= cmd_next;
            data_reg  <= data_next;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        check_next  = check_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        pkt.valid   = 1'b0;
        pkt.command = cmd_reg;
        pkt.data    = data_reg;
        if (step)
        begin
            case (pos_reg)
                POS_START:
                begin
                    if (rx_byte == start_marker)
                    begin
                        check_next = '0;
                        pos_next   = POS_COMMAND;
                    end
                end
                POS_COMMAND:
                begin
                    cmd_next   = rx_byte;
                    check_next = rx_byte & CHECK_MASK;
                    pos_next   = POS_DATA;
                end
                POS_DATA:
                begin
                    data_next  = rx_byte;
                    check_next = check_reg ^ rx_byte;
                    pos_next   = POS_CHECK;
                end
                default:
                begin
                    pos_next  = POS_START;
                    pkt.valid = (rx_byte == check_reg);
                end
            endcase
        end
    end

    assign pos = pos_reg;

endmodule

// ===== rtl/fcr_decoder.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver command decoder
// Decodes a checked packet, keeps the clock flags and holds the result.
// -----------------------------------------------------------------------------
module fcr_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  fcr_pkg::fcr_pkt_t     pkt,
    output logic                  result_valid,
    output fcr_pkg::fcr_result_t  result
);
    import fcr_pkg::*;

    logic        stop_reg, stop_next;
    logic        host_reg, host_next;
    logic        valid_reg, valid_next;
    fcr_result_t result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg  <= 1'b0;
            host_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            stop_reg  <= stop_next;
            host_reg  <= host_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        result_next          = result_reg;
        stop_next            = stop_reg;
        host_next            = host_reg;
        valid_next           = valid_reg;
        if (load)
        begin
            valid_next = pkt.valid;
            if (pkt.valid)
            begin
                result_next.action   = ACT_LOCAL;
                result_next.command  = pkt.command;
                result_next.value    = pkt.data;
                result_next.hundreds = 1'b0;
                case (pkt.command)
                    CMD_SCORE_HOME, CMD_SCORE_GUEST:
                    begin
                        if (pkt.data > SCORE_MAX)
                        begin
                            // Data never exceeds 255, so one of two subtractions suffices.
                            result_next.hundreds = 1'b1;
                            result_next.value    = (pkt.data >= SCORE_200) ?
                                                   pkt.data - SCORE_200 :
                                                   pkt.data - SCORE_100;
                        end
                    end
                    CMD_PERIOD:
                    begin
                        if (pkt.data > PERIOD_MAX)
                        begin
                            result_next.value = PERIOD_CLIP;
                        end
                    end
                    CMD_CLOCK_STOP:
                    begin
                        stop_next = (pkt.data == STOP_ON);
                        host_next = 1'b0;
                    end
                    CMD_CLOCK_ADJUST:
                    begin
                        stop_next = 1'b1;
                        host_next = 1'b1;
                    end
                    CMD_STORE_H1, CMD_STORE_H2, CMD_STORE_G1, CMD_STORE_G2, CMD_STORE_P1:
                    begin
                        result_next.action = ACT_LOCAL;
                    end
                    CMD_BUZZER:
                    begin
                        result_next.action = ACT_BUZZER;
                    end
                    default:
                    begin
                        result_next.action = ACT_FORWARD;
                    end
                endcase
                result_next.clock_stopped     = stop_next;
                result_next.clock_set_by_host = host_next;
            end
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/framed_command_receiver_top.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver top level
// Frames serial bytes into checked command packets and reports each one.
// -----------------------------------------------------------------------------
// Each accepted byte on the slave stream is one received serial byte. Bytes
// are framed into four-byte packets: the start marker, a command, a data byte
// and a checksum equal to the low nibble of the command XOR the data. Bytes
// seen while waiting for a start marker are discarded, and a packet whose
// checksum does not match is dropped; in both cases the receiver simply waits
// for the next start marker. Every good packet gives one transfer on the
// master stream carrying the command, the adjusted value (scores reduced
// modulo 100 with a hundreds flag, a period above 4 set to 10) and the game
// clock flags as they stand after the packet; tuser tells whether the command
// is stored locally, forwarded to the other board, or is a buzzer request.
// The block takes one byte every clock cycle while the master side takes its
// results. A byte is held in the input register and is then framed and
// decoded in a single pass into the result register, which drives
// m_axis_tvalid. While a result waits on the master side the byte in the
// input register is held, so at most one more byte is taken until the result
// leaves. The start marker is set through the APB port at address 0 and
// resets to zero; write it only while the stream is quiet.
// -----------------------------------------------------------------------------
`include "framed_command_receiver_top_macros.svh"

module framed_command_receiver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Slave stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    // Master stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] command, [15:8] value, [16] hundreds, [17] clock_stopped,
    // [18] clock_set_by_host, [23:19] zero
    output logic [fcr_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [fcr_pkg::TUSER_W-1:0]   m_axis_tuser,  // [1:0] action
    // APB configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcr_pkg::APB_AW-1:0]    paddr,
    input  logic [fcr_pkg::APB_DW-1:0]    pwdata,
    output logic [fcr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import fcr_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg, in_byte_next;
    logic [BYTE_W-1:0] marker_reg, marker_next;
    logic              out_free;
    logic              step;
    logic              cfg_write;
    logic              marker_sel;
    fcr_pkt_t          pkt;
    fcr_pos_t          pos;
    logic              result_valid;
    fcr_result_t       result;
    logic              at_check;
    logic              score_cmd;
    logic              hund_out;
    logic              adjust_out;
    logic              both_flags;

    // The pipeline moves whenever the result register is empty or being taken.
    assign out_free      = !result_valid || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            marker_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            marker_reg   <= marker_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata;
        end
    end

    // Register decode uses the word address; byte offsets within a word alias.
    assign pready     = 1'b1;
    assign marker_sel = (paddr[APB_AW-1] == ADDR_START_MARKER[APB_AW-1]);
    assign cfg_write  = psel && penable && pwrite && pready && marker_sel;
    assign marker_next = cfg_write ? pwdata[BYTE_W-1:0] : marker_reg;
    assign prdata     = marker_sel ? {{(APB_DW-BYTE_W){1'b0}}, marker_reg} : '0;

    fcr_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .start_marker (marker_reg),
        .pkt          (pkt),
        .pos          (pos)
    );

    fcr_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_free),
        .pkt          (pkt),
        .result_valid (result_valid),
        .result       (result)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tuser  = result.action;
    assign m_axis_tdata  = {5'd0, result.clock_set_by_host, result.clock_stopped,
                            result.hundreds, result.value, result.command};

    // Terms used by the checks below.
    assign at_check   = (pos == POS_CHECK);
    assign score_cmd  = (result.command == CMD_SCORE_HOME) ||
                        (result.command == CMD_SCORE_GUEST);
    assign hund_out   = m_axis_tvalid && result.hundreds;
    assign adjust_out = m_axis_tvalid && (result.command == CMD_CLOCK_ADJUST);
    assign both_flags = result.clock_stopped && result.clock_set_by_host;

    // A new result only comes from a checksum byte.
    `FCR_ASSERT_IMP(a_result_from_check, $rose(m_axis_tvalid), $past(at_check), "stray result")

    // After the checksum byte the framer always waits for a start marker.
    `FCR_ASSERT_NEXT(a_check_resyncs, step && at_check, pos == POS_START, "no resync")

    // The hundreds flag belongs to the score commands alone.
    `FCR_ASSERT_IMP(a_hundreds_scores, hund_out, score_cmd, "hundreds on non-score command")

    // A clock adjust leaves both clock flags set.
    `FCR_ASSERT_IMP(a_adjust_flags, adjust_out, both_flags, "clock adjust flags not set")

endmodule

// ===== verif/fcr_result_checker.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver result checker
// Watches the byte stream, the result stream and the APB port, predicts every
// result from its own copy of the framing state, and compares in order.
// -----------------------------------------------------------------------------
module fcr_result_checker
    import fcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] command, [15:8] value, [16] hundreds, [17] clock_stopped,
    // [18] clock_set_by_host, [23:19] zero
    input  logic [TDATA_W-1:0]    m_axis_tdata,
    input  logic [TUSER_W-1:0]    m_axis_tuser,   // [1:0] action
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    input  logic                  pready,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    fcr_result_t       expected_q[$];
    fcr_pos_t          slot;
    logic [BYTE_W-1:0] marker_copy;
    logic [BYTE_W-1:0] check_acc;
    logic [BYTE_W-1:0] cmd_hold;
    logic [BYTE_W-1:0] data_hold;
    logic              stop_copy;
    logic              host_copy;
    int                errors;
    int                result_no;

    assign fail_count = errors;

    task automatic report_error(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_no, msg);
        errors++;
    endtask

    // Compares one accepted result transfer against the oldest prediction.
    task automatic check_result();
        fcr_result_t want;
        if (expected_q.size() == 0)
        begin
            report_error($sformatf("unexpected result, tdata %h tuser %h",
                                   m_axis_tdata, m_axis_tuser));
        end
        else
        begin
            want = expected_q.pop_front();
            if (m_axis_tuser != want.action)
                report_error($sformatf("action got %0d want %0d",
                                       m_axis_tuser, want.action));
            if (m_axis_tdata[7:0] != want.command)
                report_error($sformatf("command got %0d want %0d",
                                       m_axis_tdata[7:0], want.command));
            if (m_axis_tdata[15:8] != want.value)
                report_error($sformatf("value got %0d want %0d",
                                       m_axis_tdata[15:8], want.value));
            if (m_axis_tdata[16] != want.hundreds)
                report_error($sformatf("hundreds got %0b want %0b",
                                       m_axis_tdata[16], want.hundreds));
            if (m_axis_tdata[17] != want.clock_stopped)
                report_error($sformatf("clock_stopped got %0b want %0b",
                                       m_axis_tdata[17], want.clock_stopped));
            if (m_axis_tdata[18] != want.clock_set_by_host)
                report_error($sformatf("clock_set_by_host got %0b want %0b",
                                       m_axis_tdata[18], want.clock_set_by_host));
            if (m_axis_tdata[23:19] != '0)
                report_error($sformatf("padding bits got %b", m_axis_tdata[23:19]));
        end
        result_no++;
    endtask

    // Advances the framing state by one byte and queues a result when a
    // packet closes with a matching checksum.
    task automatic frame_byte(input logic [BYTE_W-1:0] b);
        fcr_result_t res;
        case (slot)
            POS_START:
            begin
                if (b == marker_copy)
                begin
                    check_acc = '0;
                    slot = POS_COMMAND;
                end
            end
            POS_COMMAND:
            begin
                cmd_hold = b;
                check_acc = b & CHECK_MASK;
                slot = POS_DATA;
            end
            POS_DATA:
            begin
                data_hold = b;
                check_acc = check_acc ^ b;
                slot = POS_CHECK;
            end
            default:
            begin
                slot = POS_START;
                if (b == check_acc)
                begin
                    res.action = ACT_LOCAL;
                    res.command = cmd_hold;
                    res.value = data_hold;
                    res.hundreds = 1'b0;
                    case (cmd_hold)
                        CMD_SCORE_HOME, CMD_SCORE_GUEST:
                        begin
                            if (data_hold > SCORE_MAX)
                            begin
                                res.hundreds = 1'b1;
                                res.value = data_hold % SCORE_100;
                            end
                        end
                        CMD_PERIOD:
                        begin
                            if (data_hold > PERIOD_MAX)
                                res.value = PERIOD_CLIP;
                        end
                        CMD_CLOCK_STOP:
                        begin
                            stop_copy = (data_hold == STOP_ON);
                            host_copy = 1'b0;
                        end
                        CMD_CLOCK_ADJUST:
                        begin
                            stop_copy = 1'b1;
                            host_copy = 1'b1;
                        end
                        CMD_STORE_H1, CMD_STORE_H2, CMD_STORE_G1, CMD_STORE_G2,
                        CMD_STORE_P1:
                            ;
                        CMD_BUZZER:
                            res.action = ACT_BUZZER;
                        default:
                            res.action = ACT_FORWARD;
                    endcase
                    res.clock_stopped = stop_copy;
                    res.clock_set_by_host = host_copy;
                    expected_q.push_back(res);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            slot = POS_START;
            marker_copy = '0;
            check_acc = '0;
            cmd_hold = '0;
            data_hold = '0;
            stop_copy = 1'b0;
            host_copy = 1'b0;
            errors = 0;
            result_no = 0;
            pending <= 0;
        end
        else
        begin
            // Results leave before new bytes are framed, so a result never
            // meets a prediction made in the same cycle.
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            // The block decodes the word address only.
            if (psel && penable && pwrite && pready &&
                paddr[APB_AW-1] == ADDR_START_MARKER[APB_AW-1])
                marker_copy = pwdata[BYTE_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                frame_byte(s_axis_tdata);
            pending <= expected_q.size();
        end
    end

endmodule

// ===== verif/tb_framed_command_receiver_top.sv =====
// -----------------------------------------------------------------------------
// Framed command receiver testbench
// Drives framed command packets, noise and broken packets into the receiver
// under several start markers, with random idling on both streams, and lets
// the result checker compare every result transfer.
// -----------------------------------------------------------------------------
module tb_framed_command_receiver_top;
    import fcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The tail below gives the pipeline ample room after the last result before
    // a register write or the verdict.
    localparam int DRAIN_TAIL      = 8;
    // No legal run goes this long without any transfer.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_COUNT     = 5;
    localparam int BYTES_PER_PHASE = 350;
    // Word index one lies past the only register; writes there must be ignored.
    localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   pending;
    int                   fail_count;

    // The start marker the block holds now, kept so packets open correctly.
    logic [7:0]           marker_now;
    // Set in the last phase, when neither side idles any more.
    bit                   calm;
    int                   bytes_sent;
    int                   stall_left;
    int                   quiet_cycles;

    framed_command_receiver_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fcr_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The result side stalls in random bursts. The cycle that starts a burst
    // counts as its first cycle, and the rest of its length is drawn at random.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // The watchdog ends a run in which no transfer happens on either stream
    // for far longer than any legal pause.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offers one byte and returns at the edge where it is accepted. tvalid is
    // left high between back-to-back bytes; a random idle gap may come first.
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends one packet under the current marker. A bad packet gets its
    // checksum spoiled by a random nonzero pattern.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] data,
                              input bit bad_check);
        logic [7:0] chk;
        logic [7:0] flip;
        chk = (cmd & CHECK_MASK) ^ data;
        flip = 8'($urandom_range(1, 255));
        if (bad_check)
            chk = chk ^ flip;
        push_byte(marker_now);
        push_byte(cmd);
        push_byte(data);
        push_byte(chk);
    endtask

    // Stops the sender and waits until every predicted result has arrived,
    // then lets the pipeline settle. The first edge lets the checker's count
    // catch up with a checksum byte accepted at the current edge.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Mostly the commands the block knows, the rest any byte at all, which
    // is forwarded to the other board unless it is a known command.
    function automatic logic [7:0] pick_command();
        logic [7:0] cmd;
        case ($urandom_range(0, 15))
            0:       cmd = CMD_SCORE_HOME;
            1:       cmd = CMD_SCORE_GUEST;
            2:       cmd = CMD_PERIOD;
            3:       cmd = CMD_CLOCK_STOP;
            4:       cmd = CMD_CLOCK_ADJUST;
            5:       cmd = CMD_BUZZER;
            6:       cmd = CMD_STORE_H1;
            7:       cmd = CMD_STORE_H2;
            8:       cmd = CMD_STORE_G1;
            9:       cmd = CMD_STORE_G2;
            10:      cmd = CMD_STORE_P1;
            11:      cmd = CMD_CLOCK_STOP;
            default: cmd = 8'($urandom_range(0, 255));
        endcase
        return cmd;
    endfunction

    // Data values around the score, period and clock stop boundaries are
    // favored; the rest is uniform.
    function automatic logic [7:0] pick_data();
        logic [7:0] data;
        case ($urandom_range(0, 15))
            0:       data = 8'd0;
            1:       data = 8'd1;
            2:       data = 8'd4;
            3:       data = 8'd5;
            4:       data = 8'd99;
            5:       data = 8'd100;
            6:       data = 8'd199;
            7:       data = 8'd255;
            default: data = 8'($urandom_range(0, 255));
        endcase
        return data;
    endfunction

    // Mostly well-formed packets, with some stray bytes, truncated packets,
    // packets behind a wrong start byte and packets with a bad checksum.
    task automatic send_random_packet();
        int kind;
        int extra;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 14)
        begin
            push_byte(marker_now);
            extra = $urandom_range(0, 2);
            repeat (extra) push_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 99) < 4)
                push_byte(8'($urandom_range(0, 255)));
            send_frame(pick_command(), pick_data(), $urandom_range(0, 99) < 10);
        end
    endtask

    initial
    begin
        logic [APB_DW-1:0] word;
        int phase_start;

        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        marker_now = 8'h00;
        calm = 1'b0;
        bytes_sent = 0;
        stall_left = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets under the reset marker of zero: a stray byte in
        // the start slot, a score above 99, a period above the clamp, a clock
        // stop, a packet with a bad checksum, a clock adjust, a buzzer
        // request and a forwarded command.
        push_byte(8'h37);
        send_frame(CMD_SCORE_HOME, 8'd255, 1'b0);
        send_frame(CMD_PERIOD, 8'd5, 1'b0);
        send_frame(CMD_CLOCK_STOP, STOP_ON, 1'b0);
        send_frame(CMD_BUZZER, 8'd0, 1'b1);
        send_frame(CMD_CLOCK_ADJUST, 8'd0, 1'b0);
        send_frame(CMD_BUZZER, 8'd255, 1'b0);
        send_frame(8'hFF, 8'h00, 1'b0);

        // Random phases, each under its own start marker. The marker is
        // only rewritten once the stream has drained; the upper word bits
        // are random so every bit of pwdata toggles.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            case (p)
                0:       marker_now = 8'hFF;
                2:       marker_now = 8'h00;
                4:       marker_now = 8'hA5;
                default: marker_now = 8'($urandom_range(0, 255));
            endcase
            word = $urandom;
            word[7:0] = marker_now;
            apb_write(ADDR_START_MARKER, word);
            if (p == 1)
            begin
                // The bus goes idle between the two writes.
                @(posedge clk);
                apb_write(ADDR_SPARE, $urandom);
            end
            calm = (p == PHASE_COUNT - 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE)
            begin
                send_random_packet();
                // Now and then the sender holds off until all results are in.
                if (!calm && $urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
